### sv/oled_page_frame_buffer_top_assert.svh
// assertion macros for the page frame buffer
`ifndef OLED_PAGE_FRAME_BUFFER_TOP_ASSERT_SVH
`define OLED_PAGE_FRAME_BUFFER_TOP_ASSERT_SVH

// condition must never hold while out of reset
`define OPF_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("opf: forbidden condition seen");

// antecedent implies consequent in the same cycle
`define OPF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("opf: implication failed");

`endif

### sv/opf_pkg.sv
// shared types and constants for the page frame buffer
`default_nettype none

package opf_pkg;

    localparam int COLUMNS_DEF = 128;
    localparam int PAGES_DEF   = 8;

    localparam int COL_W       = 8;
    localparam int GRP_W       = 4;
    localparam int HEADER_LEN  = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CTRL_COMMAND  = 8'h00;
    localparam logic [7:0] CTRL_DATA     = 8'h40;
    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_LOW   = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

    typedef enum logic [1:0] {
        OP_POINT   = 2'd0,
        OP_RECT    = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_REFRESH = 2'd3
    } t_op_code;

    typedef enum logic [1:0] {
        CMD_RECT,
        CMD_CLEAR,
        CMD_REFRESH
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [COL_W-1:0]   x0;
        logic [COL_W-1:0]   x1;
        logic [GRP_W-1:0]   g0;
        logic [GRP_W-1:0]   g1;
        logic [2:0]         y0_lo;
        logic [2:0]         y1_lo;
        logic               value;
        logic [7:0]         fill;
    } t_cmd;

endpackage

`default_nettype wire

### sv/oled_page_frame_buffer_top.sv
// top level of the page frame buffer
//
// input channel: i_valid / o_stall carry one operation beat (point, box fill,
// clear, refresh step); a beat is taken when i_valid is high and o_stall low.
// output channel: o_valid / i_stall carry one stream byte for each refresh
// step: control byte, payload byte and the frame_last flag on the final data
// byte of the last page. points, boxes and clears produce no output beat.
// a refresh beat passes the queue, back stage and output registers. the walker
// takes one store byte a cycle unless a stalled output holds its back stage: a
// point or refresh step is one byte, a box each store byte it touches, a clear
// every store entry (1024 at 128 x 8); the single frame store port (one read
// and one write a cycle) and the walker set this pace. a four-entry queue sits
// between front and back. after reset the store is swept to zero, one byte a
// cycle (1024 entries at 128 x 8) while o_stall stays high; the stream restarts
// at page 0. a stalled output holds its beat; the back end keeps working until
// it needs the output register, then the queue fills and o_stall rises.
`default_nettype none

`include "oled_page_frame_buffer_top_assert.svh"

module oled_page_frame_buffer_top #(
    parameter int COLUMNS = opf_pkg::COLUMNS_DEF,
    parameter int PAGES   = opf_pkg::PAGES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_operation,
    input  wire logic [7:0] i_x_start,
    input  wire logic [7:0] i_y_start,
    input  wire logic [7:0] i_x_end,
    input  wire logic [7:0] i_y_end,
    input  wire logic       i_pixel_value,
    input  wire logic [7:0] i_fill_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_control_byte,
    output logic [7:0]      o_payload_byte,
    output logic            o_frame_last
);

    logic          q_push;
    logic          q_pop;
    logic          q_valid;
    logic          q_full;
    logic          busy;
    opf_pkg::t_cmd f_cmd;
    opf_pkg::t_cmd q_cmd;

    opf_front #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_front (
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_x_start     (i_x_start),
        .i_y_start     (i_y_start),
        .i_x_end       (i_x_end),
        .i_y_end       (i_y_end),
        .i_pixel_value (i_pixel_value),
        .i_fill_byte   (i_fill_byte),
        .i_queue_full  (q_full),
        .i_busy        (busy),
        .o_push        (q_push),
        .o_cmd         (f_cmd)
    );

    opf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (q_cmd)
    );

    opf_back #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_cmd        (q_cmd),
        .o_q_pop        (q_pop),
        .o_busy         (busy),
        .i_out_stall    (i_stall),
        .o_out_valid    (o_valid),
        .o_control_byte (o_control_byte),
        .o_payload_byte (o_payload_byte),
        .o_frame_last   (o_frame_last)
    );

    `OPF_ASSERT_NEVER(a_push_when_full, i_clk, i_rst_n, q_push && q_full)
    `OPF_ASSERT_NEVER(a_pop_when_empty, i_clk, i_rst_n, q_pop && !q_valid)
    `OPF_ASSERT_IMPLY(a_no_pop_in_sweep, i_clk, i_rst_n, busy, !q_pop)
    `OPF_ASSERT_IMPLY(a_last_is_data, i_clk, i_rst_n, o_valid && o_frame_last,
                      o_control_byte == opf_pkg::CTRL_DATA)

endmodule

`default_nettype wire

### sv/opf_front.sv
// front end: accepts input beats, drops off-screen draws, clamps boxes
`default_nettype none

module opf_front #(
    parameter int COLUMNS = opf_pkg::COLUMNS_DEF,
    parameter int PAGES   = opf_pkg::PAGES_DEF
) (
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_operation,
    input  wire logic [7:0] i_x_start,
    input  wire logic [7:0] i_y_start,
    input  wire logic [7:0] i_x_end,
    input  wire logic [7:0] i_y_end,
    input  wire logic       i_pixel_value,
    input  wire logic [7:0] i_fill_byte,
    input  wire logic       i_queue_full,
    input  wire logic       i_busy,
    output logic            o_push,
    output opf_pkg::t_cmd   o_cmd
);

    localparam int ROWS = PAGES * 8;
    localparam logic [8:0] COL_LIM = 9'(COLUMNS);
    localparam logic [8:0] ROW_LIM = 9'(ROWS);

    logic       xs_on;
    logic       ys_on;
    logic [7:0] x_end_c;
    logic [7:0] y_end_c;
    logic       keep;

    assign o_stall = i_queue_full || i_busy;

    always_comb begin
        xs_on   = {1'b0, i_x_start} < COL_LIM;
        ys_on   = {1'b0, i_y_start} < ROW_LIM;
        x_end_c = ({1'b0, i_x_end} >= COL_LIM) ? 8'(COLUMNS - 1) : i_x_end;
        y_end_c = ({1'b0, i_y_end} >= ROW_LIM) ? 8'(ROWS - 1) : i_y_end;

        o_cmd.kind  = opf_pkg::CMD_RECT;
        o_cmd.x0    = i_x_start;
        o_cmd.x1    = i_x_start;
        o_cmd.g0    = opf_pkg::GRP_W'(i_y_start >> 3);
        o_cmd.g1    = opf_pkg::GRP_W'(i_y_start >> 3);
        o_cmd.y0_lo = i_y_start[2:0];
        o_cmd.y1_lo = i_y_start[2:0];
        o_cmd.value = i_pixel_value;
        o_cmd.fill  = i_fill_byte;
        keep        = 1'b0;

        unique case (opf_pkg::t_op_code'(i_operation))
            opf_pkg::OP_POINT: begin
                keep = xs_on && ys_on;
            end
            opf_pkg::OP_RECT: begin
                o_cmd.x1    = x_end_c;
                o_cmd.g1    = opf_pkg::GRP_W'(y_end_c >> 3);
                o_cmd.y1_lo = y_end_c[2:0];
                keep = xs_on && ys_on && (i_x_start <= x_end_c) && (i_y_start <= y_end_c);
            end
            opf_pkg::OP_CLEAR: begin
                o_cmd.kind = opf_pkg::CMD_CLEAR;
                keep       = 1'b1;
            end
            opf_pkg::OP_REFRESH: begin
                o_cmd.kind = opf_pkg::CMD_REFRESH;
                keep       = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase

        o_push = i_valid && !o_stall && keep;
    end

endmodule

`default_nettype wire

### sv/opf_queue.sv
// short command queue between front end and back end
`default_nettype none

module opf_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire opf_pkg::t_cmd  i_cmd,
    input  wire logic           i_pop,
    output logic                o_valid,
    output logic                o_full,
    output opf_pkg::t_cmd       o_cmd
);

    localparam int DEPTH = opf_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    opf_pkg::t_cmd    r_entries [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_valid = r_count != '0;
    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_cmd   = r_entries[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entries[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

### sv/opf_back.sv
// back end: byte walker, frame store with read-modify-write stage, output register
`default_nettype none

module opf_back #(
    parameter int COLUMNS = opf_pkg::COLUMNS_DEF,
    parameter int PAGES   = opf_pkg::PAGES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire opf_pkg::t_cmd i_q_cmd,
    output logic               o_q_pop,
    output logic               o_busy,
    input  wire logic          i_out_stall,
    output logic               o_out_valid,
    output logic [7:0]         o_control_byte,
    output logic [7:0]         o_payload_byte,
    output logic               o_frame_last
);

    localparam int CW    = $clog2(COLUMNS);
    localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int AW    = CW + PW;
    localparam int RPW   = $clog2(COLUMNS + opf_pkg::HEADER_LEN);
    localparam int GW    = opf_pkg::GRP_W;

    typedef enum logic [1:0] {
        B_WMASK,
        B_WFULL,
        B_EMIT_CMD,
        B_EMIT_DATA
    } t_bop;

    typedef struct packed {
        t_bop          op;
        logic [AW-1:0] addr;
        logic [7:0]    mask;
        logic          value;
        logic [7:0]    data;
        logic          last;
    } t_issue;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_RECT,
        S_CLEAR
    } t_state;

    logic [7:0]     mem [2**AW];
    logic [7:0]     r_rd_data;

    t_state         r_state,    n_state;
    logic [AW-1:0]  r_addr,     n_addr;
    logic [CW-1:0]  r_col,      n_col;
    logic [GW-1:0]  r_grp,      n_grp;
    opf_pkg::t_cmd  r_cmd,      n_cmd;
    logic [RPW-1:0] r_ref_pos,  n_ref_pos;
    logic [PW-1:0]  r_ref_page, n_ref_page;
    logic           r_b_valid;
    t_issue         r_b;
    logic           r_out_valid;
    logic [7:0]     r_out_ctrl;
    logic [7:0]     r_out_payload;
    logic           r_out_last;

    logic           issue_valid;
    t_issue         issue;
    logic           b_emit;
    logic           b_fire;
    logic           b_ready;
    logic           wr_en;
    logic [7:0]     wr_data;
    logic           rd_en;

    opf_pkg::t_cmd  cur_cmd;
    logic [CW-1:0]  cur_col;
    logic [GW-1:0]  cur_grp;
    logic           rect_done;
    logic [CW-1:0]  adv_col;
    logic [GW-1:0]  adv_grp;
    logic [CW-1:0]  ref_col;

    function automatic logic [7:0] rect_mask(input logic [GW-1:0] grp,
                                             input opf_pkg::t_cmd cmd);
        logic [2:0] lo;
        logic [2:0] hi;
        lo = (grp == cmd.g0) ? cmd.y0_lo : 3'd0;
        hi = (grp == cmd.g1) ? cmd.y1_lo : 3'd7;
        return (8'hFF >> lo) & (8'hFF << (3'd7 - hi));
    endfunction

    function automatic logic [AW-1:0] byte_addr(input logic [CW-1:0] col,
                                                input logic [GW-1:0] grp);
        logic [PW-1:0] page;
        page = PW'(PAGES - 1) - PW'(grp);
        return {col, page};
    endfunction

    // back stage handshake
    assign b_emit  = (r_b.op == B_EMIT_CMD) || (r_b.op == B_EMIT_DATA);
    assign b_fire  = r_b_valid && (!b_emit || !r_out_valid || !i_out_stall);
    assign b_ready = !r_b_valid || b_fire;

    assign wr_en   = b_fire && ((r_b.op == B_WMASK) || (r_b.op == B_WFULL));
    assign wr_data = (r_b.op == B_WFULL) ? r_b.data :
                     (r_b.value ? (r_rd_data | r_b.mask) : (r_rd_data & ~r_b.mask));
    assign rd_en   = issue_valid && ((issue.op == B_WMASK) || (issue.op == B_EMIT_DATA));

    assign o_busy         = r_state == S_INIT;
    assign o_out_valid    = r_out_valid;
    assign o_control_byte = r_out_ctrl;
    assign o_payload_byte = r_out_payload;
    assign o_frame_last   = r_out_last;

    // box walk: groups inner, columns outer
    always_comb begin
        cur_cmd   = (r_state == S_RECT) ? r_cmd : i_q_cmd;
        cur_col   = (r_state == S_RECT) ? r_col : CW'(i_q_cmd.x0);
        cur_grp   = (r_state == S_RECT) ? r_grp : i_q_cmd.g0;
        rect_done = (cur_col == CW'(cur_cmd.x1)) && (cur_grp == cur_cmd.g1);
        adv_col   = (cur_grp == cur_cmd.g1) ? cur_col + 1'b1 : cur_col;
        adv_grp   = (cur_grp == cur_cmd.g1) ? cur_cmd.g0 : cur_grp + 1'b1;
        ref_col   = CW'(r_ref_pos - RPW'(opf_pkg::HEADER_LEN));
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_col       = r_col;
        n_grp       = r_grp;
        n_cmd       = r_cmd;
        n_ref_pos   = r_ref_pos;
        n_ref_page  = r_ref_page;
        o_q_pop     = 1'b0;
        issue_valid = 1'b0;
        issue.op    = B_WFULL;
        issue.addr  = r_addr;
        issue.mask  = 8'h00;
        issue.value = 1'b0;
        issue.data  = 8'h00;
        issue.last  = 1'b0;

        if (b_ready) begin
            unique case (r_state)
                S_INIT, S_CLEAR: begin
                    issue_valid = 1'b1;
                    issue.op    = B_WFULL;
                    issue.addr  = r_addr;
                    issue.data  = (r_state == S_INIT) ? 8'h00 : r_cmd.fill;
                    n_addr      = r_addr + 1'b1;
                    if (r_addr == '1) begin
                        n_state = S_IDLE;
                    end
                end
                S_RECT: begin
                    issue_valid = 1'b1;
                    issue.op    = B_WMASK;
                    issue.addr  = byte_addr(cur_col, cur_grp);
                    issue.mask  = rect_mask(cur_grp, cur_cmd);
                    issue.value = cur_cmd.value;
                    n_col       = adv_col;
                    n_grp       = adv_grp;
                    if (rect_done) begin
                        n_state = S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        o_q_pop     = 1'b1;
                        issue_valid = 1'b1;
                        n_cmd       = i_q_cmd;
                        unique case (i_q_cmd.kind)
                            opf_pkg::CMD_RECT: begin
                                issue.op    = B_WMASK;
                                issue.addr  = byte_addr(cur_col, cur_grp);
                                issue.mask  = rect_mask(cur_grp, cur_cmd);
                                issue.value = cur_cmd.value;
                                n_col       = adv_col;
                                n_grp       = adv_grp;
                                if (!rect_done) begin
                                    n_state = S_RECT;
                                end
                            end
                            opf_pkg::CMD_CLEAR: begin
                                issue.op   = B_WFULL;
                                issue.addr = '0;
                                issue.data = i_q_cmd.fill;
                                n_addr     = AW'(1);
                                n_state    = S_CLEAR;
                            end
                            opf_pkg::CMD_REFRESH: begin
                                issue.op = B_EMIT_CMD;
                                priority if (r_ref_pos == RPW'(0)) begin
                                    issue.data = opf_pkg::CMD_PAGE_BASE + 8'(r_ref_page);
                                end else if (r_ref_pos == RPW'(1)) begin
                                    issue.data = opf_pkg::CMD_COL_LOW;
                                end else if (r_ref_pos == RPW'(2)) begin
                                    issue.data = opf_pkg::CMD_COL_HIGH;
                                end else begin
                                    issue.op   = B_EMIT_DATA;
                                    issue.addr = {ref_col, r_ref_page};
                                    issue.last = (ref_col == CW'(COLUMNS - 1)) &&
                                                 (r_ref_page == PW'(PAGES - 1));
                                end
                                if (r_ref_pos == RPW'(COLUMNS + opf_pkg::HEADER_LEN - 1)) begin
                                    n_ref_pos  = '0;
                                    n_ref_page = (r_ref_page == PW'(PAGES - 1)) ?
                                                 '0 : r_ref_page + 1'b1;
                                end else begin
                                    n_ref_pos = r_ref_pos + 1'b1;
                                end
                            end
                            default: begin
                                issue_valid = 1'b0;
                            end
                        endcase
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    // frame store, write-first on a same-address collision
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_b.addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= (wr_en && (r_b.addr == issue.addr)) ? wr_data : mem[issue.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_addr      <= '0;
            r_ref_pos   <= '0;
            r_ref_page  <= '0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_addr     <= n_addr;
            r_ref_pos  <= n_ref_pos;
            r_ref_page <= n_ref_page;
            if (b_ready) begin
                r_b_valid <= issue_valid;
            end
            if (b_fire && b_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        r_col <= n_col;
        r_grp <= n_grp;
        r_cmd <= n_cmd;
        if (b_ready) begin
            r_b <= issue;
        end
        if (b_fire && b_emit) begin
            r_out_ctrl    <= (r_b.op == B_EMIT_DATA) ? opf_pkg::CTRL_DATA :
                                                       opf_pkg::CTRL_COMMAND;
            r_out_payload <= (r_b.op == B_EMIT_DATA) ? r_rd_data : r_b.data;
            r_out_last    <= r_b.last;
        end
    end

endmodule

`default_nettype wire
